// ----- hw/rtl/tgarle_pkg.sv -----
// tgarle_pkg: shared constants and types for the TGA run-length pixel decoder.
// No dependencies; imported by tga_rle_pixel_decoder.
package tgarle_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_COMPRESSED   = 2'd0;
    localparam logic [1:0] REG_GREYSCALE    = 2'd1;
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd2;
    localparam logic [1:0] REG_PIXEL_COUNT  = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W    = 32;

    // true-color format codes
    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;
    localparam logic [1:0] FMT_32 = 2'd2;

    // packet header fields
    localparam logic [7:0] HDR_RUN_BIT  = 8'h80;
    localparam logic [7:0] HDR_LEN_MASK = 8'h7f;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic  pixel_valid;
        t_byte red;
        t_byte green;
        t_byte blue;
        t_byte repeat_res;
        logic  image_done;
        logic  truncated;
    } t_result;

endpackage

// ----- hw/rtl/tga_rle_pixel_decoder.sv -----
// tga_rle_pixel_decoder: turns TGA pixel-data bytes (RLE or raw) into color runs.
// Depends on tgarle_pkg (constants, result struct).
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_data_byte, i_stream_end
//  out     | source    | o_out_valid / i_out_ready  | o_pixel_valid .. o_truncated
//  cfg     | sink      | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One byte per cycle while o_in_ready is high; a result appears in the output register the cycle after its byte.
// The per-byte path is one 33-bit subtract of pixels done from pixel count plus an 8-bit
// compare and a 32-bit add, all between the state registers and the output register.
// o_in_ready drops only while a result is held and i_out_ready is low.
// Synchronous active-low reset clears stream state, config to defaults, no result held.
module tga_rle_pixel_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config
    input  logic                           i_cfg_we,
    input  logic [tgarle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // byte stream in
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_stream_end,
    // results out
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_pixel_valid,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue,
    output logic [7:0]                     o_repeat_res,
    output logic                           o_image_done,
    output logic                           o_truncated
);
    import tgarle_pkg::*;

    // config registers
    logic               r_compressed;
    logic               r_greyscale;
    logic [1:0]         r_pixel_format;
    logic [COUNT_W-1:0] r_pixel_count;

    // stream state
    logic               r_expect_header, n_expect_header;
    logic               r_run_packet,    n_run_packet;
    logic [7:0]         r_packet_left,   n_packet_left;
    logic [1:0]         r_byte_in_pixel, n_byte_in_pixel;
    logic [23:0]        r_pixel_bytes,   n_pixel_bytes;
    logic [COUNT_W-1:0] r_pixels_done,   n_pixels_done;

    // output register
    logic               r_out_valid;
    t_result            r_out, n_out;

    logic               in_fire;
    logic [COUNT_W:0]   remain_ext;
    logic               img_full;
    logic               hdr_now;
    logic [1:0]         need_m1;
    logic [23:0]        bytes_mrg;
    logic               pix_done;
    logic               remain_small;
    logic [7:0]         rep_raw;
    logic [7:0]         rep_clip;
    logic               done_now;
    logic               result_now;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // remaining = count - done; borrow means done already past count
    assign remain_ext   = {1'b0, r_pixel_count} - {1'b0, r_pixels_done};
    assign img_full     = remain_ext[COUNT_W] || (remain_ext[COUNT_W-1:0] == '0);
    assign remain_small = (remain_ext[COUNT_W-1:8] == '0);
    assign hdr_now      = r_compressed && r_expect_header;

    // last byte position of a pixel; unused format code behaves as 32 bit
    always_comb begin
        if (r_greyscale) begin
            need_m1 = 2'd0;
        end else begin
            case (r_pixel_format)
                FMT_16:  need_m1 = 2'd1;
                FMT_24:  need_m1 = 2'd2;
                FMT_32:  need_m1 = 2'd3;
                default: need_m1 = 2'd3;
            endcase
        end
    end

    always_comb begin
        bytes_mrg = r_pixel_bytes;
        case (r_byte_in_pixel)
            2'd0:    bytes_mrg[7:0]   = r_pixel_bytes[7:0]   | i_data_byte;
            2'd1:    bytes_mrg[15:8]  = r_pixel_bytes[15:8]  | i_data_byte;
            2'd2:    bytes_mrg[23:16] = r_pixel_bytes[23:16] | i_data_byte;
            default: bytes_mrg = r_pixel_bytes;  // alpha byte is dropped
        endcase
    end

    assign pix_done = !img_full && !hdr_now && (r_byte_in_pixel >= need_m1);

    always_comb begin
        if (r_compressed && r_run_packet) begin
            rep_raw = r_packet_left;
        end else begin
            rep_raw = 8'd1;
        end
    end

    // clip to pixels still missing; remaining is nonzero whenever a pixel completes
    always_comb begin
        if (remain_small && (rep_raw >= remain_ext[7:0])) begin
            rep_clip = remain_ext[7:0];
            done_now = 1'b1;
        end else begin
            rep_clip = rep_raw;
            done_now = 1'b0;
        end
    end

    assign result_now = !img_full && (pix_done || i_stream_end);

    // next stream state
    always_comb begin
        n_expect_header = r_expect_header;
        n_run_packet    = r_run_packet;
        n_packet_left   = r_packet_left;
        n_byte_in_pixel = r_byte_in_pixel;
        n_pixel_bytes   = r_pixel_bytes;
        n_pixels_done   = r_pixels_done;
        if (img_full) begin
            // image complete: bytes ignored until the end of the stream
        end else if (hdr_now) begin
            n_run_packet    = |(i_data_byte & HDR_RUN_BIT);
            n_packet_left   = (i_data_byte & HDR_LEN_MASK) + 8'd1;
            n_expect_header = 1'b0;
            n_byte_in_pixel = 2'd0;
            n_pixel_bytes   = '0;
        end else if (pix_done) begin
            if (r_compressed) begin
                if (r_run_packet) begin
                    n_packet_left = 8'd0;
                end else begin
                    n_packet_left = r_packet_left - 8'd1;
                end
                if (n_packet_left == 8'd0) begin
                    n_expect_header = 1'b1;
                end
            end
            n_pixels_done   = r_pixels_done + {{(COUNT_W-8){1'b0}}, rep_clip};
            n_byte_in_pixel = 2'd0;
            n_pixel_bytes   = '0;
        end else begin
            n_byte_in_pixel = r_byte_in_pixel + 2'd1;
            n_pixel_bytes   = bytes_mrg;
        end
        if (i_stream_end) begin
            n_expect_header = 1'b1;
            n_run_packet    = 1'b0;
            n_packet_left   = '0;
            n_byte_in_pixel = '0;
            n_pixel_bytes   = '0;
            n_pixels_done   = '0;
        end
    end

    // result word
    always_comb begin
        n_out             = '0;
        n_out.pixel_valid = pix_done;
        if (pix_done) begin
            if (r_greyscale) begin
                n_out.red = bytes_mrg[7:0];
            end else if (need_m1 == 2'd1) begin
                // 5:5:5 expanded, red from bits 14..10
                n_out.blue  = {bytes_mrg[4:0], 3'b000};
                n_out.green = {bytes_mrg[9:8], bytes_mrg[7:5], 3'b000};
                n_out.red   = {bytes_mrg[14:10], 3'b000};
            end else begin
                n_out.blue  = bytes_mrg[7:0];
                n_out.green = bytes_mrg[15:8];
                n_out.red   = bytes_mrg[23:16];
            end
            n_out.repeat_res = rep_clip;
            n_out.image_done = done_now;
        end
        n_out.truncated = i_stream_end && !(pix_done && done_now);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed    <= 1'b1;
            r_greyscale     <= 1'b0;
            r_pixel_format  <= FMT_24;
            r_pixel_count   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COMPRESSED:   r_compressed   <= i_cfg_data[0];
                REG_GREYSCALE:    r_greyscale    <= i_cfg_data[0];
                REG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data[1:0];
                REG_PIXEL_COUNT:  r_pixel_count  <= i_cfg_data[COUNT_W-1:0];
                default:          r_pixel_count  <= r_pixel_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_run_packet    <= 1'b0;
            r_packet_left   <= '0;
            r_byte_in_pixel <= '0;
            r_pixel_bytes   <= '0;
            r_pixels_done   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_expect_header <= n_expect_header;
                r_run_packet    <= n_run_packet;
                r_packet_left   <= n_packet_left;
                r_byte_in_pixel <= n_byte_in_pixel;
                r_pixel_bytes   <= n_pixel_bytes;
                r_pixels_done   <= n_pixels_done;
                r_out_valid     <= result_now;
            end else if (i_out_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && result_now) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_valid = r_out.pixel_valid;
    assign o_red         = r_out.red;
    assign o_green       = r_out.green;
    assign o_blue        = r_out.blue;
    assign o_repeat_res  = r_out.repeat_res;
    assign o_image_done  = r_out.image_done;
    assign o_truncated   = r_out.truncated;

    // a pixel word always carries at least one pixel
    a_rep_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pixel_valid) |-> (o_repeat_res != 8'd0))
        else $error("pixel word with zero repeat");

    // a word without a pixel exists only to flag truncation
    a_empty_is_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_pixel_valid) |-> (o_truncated && !o_image_done))
        else $error("empty result word not flagged truncated");

    // completion and truncation never come together
    a_done_xor_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_image_done && o_truncated))
        else $error("image both done and truncated");

    // end of stream returns the stream state to its start
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_stream_end) |=> (r_pixels_done == '0 && r_expect_header
                                       && r_byte_in_pixel == 2'd0))
        else $error("stream state not cleared after end of stream");

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for tga_rle_pixel_decoder, with random stalls on both channels.
// Depends on tgarle_pkg and the decoder RTL; a small class predicts and checks the pixel runs.
module testbench;
    import tgarle_pkg::*;

    localparam logic [1:0]  FMT_SPARE    = 2'd3;          // unused code, decodes as 32 bit
    localparam logic [31:0] MAX_COUNT    = 32'hFFFE_0001; // 65535 x 65535
    localparam int          RANDOM_BYTES = 500;
    localparam int          SETTLE       = 4;
    localparam int          LIMIT        = 400000;

    // expected runs for every accepted byte, plus the check of what comes out
    class run_board;
        logic        compressed;
        logic        greyscale;
        logic [1:0]  pixel_format;
        logic [31:0] pixel_count;
        logic        hdr_due;
        logic        run_pkt;
        logic [7:0]  pkt_left;
        logic [1:0]  byte_idx;
        logic [23:0] px_bytes;
        logic [31:0] px_done;
        t_result     pending_runs[$];
        int          errors;
        int          runs_checked;
        int          truncations;
        int          images_done;
        int          live_bytes;

        function new();
            compressed   = 1'b1;
            greyscale    = 1'b0;
            pixel_format = FMT_24;
            pixel_count  = '0;
            errors       = 0;
            runs_checked = 0;
            truncations  = 0;
            images_done  = 0;
            live_bytes   = 0;
            restart();
        endfunction

        function void restart();
            hdr_due  = 1'b1;
            run_pkt  = 1'b0;
            pkt_left = '0;
            byte_idx = '0;
            px_bytes = '0;
            px_done  = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_COMPRESSED:   compressed   = val[0];
                REG_GREYSCALE:    greyscale    = val[0];
                REG_PIXEL_FORMAT: pixel_format = val[1:0];
                REG_PIXEL_COUNT:  pixel_count  = val;
                default: ;
            endcase
        endfunction

        function int unsigned pixel_size();
            if (greyscale)
                return 1;
            case (pixel_format)
                FMT_16:  return 2;
                FMT_24:  return 3;
                default: return 4;
            endcase
        endfunction

        function void note_byte(t_byte d, logic last);
            t_result     r;
            int unsigned need;
            logic [31:0] remaining;
            logic [31:0] rep;
            t_byte       b0, b1, b2;
            r = '0;
            // image already full: swallow bytes until the stream ends
            if (px_done >= pixel_count) begin
                if (last)
                    restart();
                return;
            end
            live_bytes++;
            if (compressed && hdr_due) begin
                run_pkt  = d[7];
                pkt_left = {1'b0, d[6:0]} + 8'd1;
                hdr_due  = 1'b0;
                byte_idx = '0;
                px_bytes = '0;
            end else begin
                need = pixel_size();
                if (byte_idx < 2'd3)
                    px_bytes[8*byte_idx +: 8] = d;
                if (int'(byte_idx) + 1 >= need) begin
                    b0 = px_bytes[7:0];
                    b1 = px_bytes[15:8];
                    b2 = px_bytes[23:16];
                    remaining = pixel_count - px_done;
                    if (greyscale) begin
                        r.red = b0;
                    end else if (need == 2) begin
                        r.blue  = {b0[4:0], 3'b000};
                        r.green = {b1[1:0], b0[7:5], 3'b000};
                        r.red   = {b1[6:2], 3'b000};
                    end else begin
                        r.blue  = b0;
                        r.green = b1;
                        r.red   = b2;
                    end
                    if (compressed) begin
                        if (run_pkt) begin
                            rep      = {24'd0, pkt_left};
                            pkt_left = '0;
                        end else begin
                            rep      = 32'd1;
                            pkt_left = pkt_left - 8'd1;
                        end
                        if (pkt_left == 8'd0)
                            hdr_due = 1'b1;
                    end else begin
                        rep = 32'd1;
                    end
                    if (rep > remaining)
                        rep = remaining;
                    px_done       = px_done + rep;
                    r.pixel_valid = 1'b1;
                    r.repeat_res  = rep[7:0];
                    r.image_done  = (px_done >= pixel_count);
                    byte_idx      = '0;
                    px_bytes      = '0;
                end else begin
                    byte_idx = byte_idx + 2'd1;
                end
            end
            if (!r.pixel_valid && !last)
                return;
            r.truncated = last && !r.image_done;
            pending_runs.push_back(r);
            if (last)
                restart();
        endfunction

        function void check_run(t_result got);
            t_result want;
            if (pending_runs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected: valid=%0b rgb=%02h%02h%02h rep=%0d done=%0b trunc=%0b",
                             got.pixel_valid, got.red, got.green, got.blue, got.repeat_res,
                             got.image_done, got.truncated);
                return;
            end
            want = pending_runs.pop_front();
            runs_checked++;
            if (want.image_done)
                images_done++;
            if (want.truncated)
                truncations++;
            if (got.pixel_valid !== want.pixel_valid || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.repeat_res !== want.repeat_res || got.image_done !== want.image_done ||
                got.truncated !== want.truncated) begin
                errors++;
                if (errors <= 10) begin
                    $display("run %0d mismatch: exp valid=%0b rgb=%02h%02h%02h rep=%0d %s",
                             runs_checked, want.pixel_valid, want.red, want.green,
                             want.blue, want.repeat_res,
                             $sformatf("done=%0b trunc=%0b", want.image_done,
                                       want.truncated));
                    $display("    got valid=%0b rgb=%02h%02h%02h rep=%0d done=%0b trunc=%0b",
                             got.pixel_valid, got.red, got.green, got.blue,
                             got.repeat_res, got.image_done, got.truncated);
                end
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte  = '0;
    logic        i_stream_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic        o_pixel_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_repeat_res;
    logic        o_image_done;
    logic        o_truncated;

    int          send_idle = 38;
    int          recv_idle = 78;
    int          cycles    = 0;
    run_board    sb        = new();

    tga_rle_pixel_decoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_valid(o_pixel_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_repeat_res (o_repeat_res),
        .o_image_done (o_image_done),
        .o_truncated  (o_truncated)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tga_rle_pixel_decoder test failed");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge i_clk) begin : out_side
        t_result seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{pixel_valid: o_pixel_valid, red: o_red, green: o_green, blue: o_blue,
                     repeat_res: o_repeat_res, image_done: o_image_done,
                     truncated: o_truncated};
            sb.check_run(seen);
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_byte(input t_byte d, input logic last);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= d;
        i_stream_end <= last;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_byte(d, last);
    endtask

    // drain all expected runs, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_runs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    // one image: packets (or bare pixels) with random colors, end flagged on the last byte
    task automatic send_image(input int unsigned target, input bit cut, input bit junk);
        t_byte       stream[$];
        int unsigned bpp, made, len, drop, most, r;
        bit          run;
        bpp  = sb.pixel_size();
        made = 0;
        while (made < target) begin
            if (sb.compressed) begin
                run = $urandom_range(1);
                r   = $urandom_range(99);
                len = (r < 70) ? $urandom_range(4, 1) :
                      (r < 90) ? $urandom_range(16, 5) : $urandom_range(128, 17);
                if (!run && len > 8)
                    len = $urandom_range(8, 1);
                stream.push_back({run, 7'(len - 1)});
                repeat (run ? bpp : bpp * len) stream.push_back(t_byte'($urandom));
                made += len;
            end else begin
                repeat (bpp) stream.push_back(t_byte'($urandom));
                made++;
            end
        end
        if (junk || stream.size() == 0)
            repeat ($urandom_range(4, 1)) stream.push_back(t_byte'($urandom));
        if (cut && stream.size() > 1) begin
            most = (stream.size() - 1 < 3) ? stream.size() - 1 : 3;
            drop = $urandom_range(most, 1);
            repeat (drop) void'(stream.pop_back());
        end
        foreach (stream[k])
            send_byte(stream[k], k == stream.size() - 1);
    endtask

    initial begin : main
        int          start, part, n, r;
        logic [31:0] count;
        int unsigned target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: run-length, 24 bit, empty image, so all is ignored
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // run of 128 clipped to a 3-pixel image, then a trailing byte ignored
        write_reg(REG_PIXEL_COUNT, 32'd3);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h5A, 1'b1);
        // 16-bit raw packet in a huge image, stream ends on a header
        write_reg(REG_PIXEL_FORMAT, 32'(FMT_16));
        write_reg(REG_PIXEL_COUNT, MAX_COUNT);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        // raw greyscale, end lands on a pixel
        write_reg(REG_COMPRESSED, 32'd0);
        write_reg(REG_GREYSCALE, 32'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // spare format code behaves as 32 bit
        write_reg(REG_COMPRESSED, 32'd1);
        write_reg(REG_GREYSCALE, 32'd0);
        write_reg(REG_PIXEL_FORMAT, 32'(FMT_SPARE));
        write_reg(REG_PIXEL_COUNT, 32'd2);
        send_byte(8'h81, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h00, 1'b1);
        // shrink the format while a pixel is half assembled
        write_reg(REG_PIXEL_FORMAT, 32'(FMT_32));
        write_reg(REG_PIXEL_COUNT, 32'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        write_reg(REG_PIXEL_FORMAT, 32'(FMT_16));
        send_byte(8'hA5, 1'b1);

        start = sb.live_bytes;
        while (sb.live_bytes < start + RANDOM_BYTES) begin
            part = (sb.live_bytes - start) * 3 / RANDOM_BYTES;
            if (part == 0) begin
                send_idle  = 38;
                recv_idle <= 78;
            end else if (part == 1) begin
                send_idle  = 78;
                recv_idle <= 38;
            end else begin
                send_idle  = 0;
                recv_idle <= 0;
            end
            r = $urandom_range(9);
            count = (r == 0) ? 32'd0 : (r == 1) ? MAX_COUNT : (r == 2) ? 32'd1 :
                    32'($urandom_range(40, 2));
            write_reg(REG_COMPRESSED, 32'($urandom_range(1)));
            write_reg(REG_GREYSCALE, 32'($urandom_range(3) == 0));
            write_reg(REG_PIXEL_FORMAT, 32'($urandom_range(2)));
            write_reg(REG_PIXEL_COUNT, count);
            repeat (3) begin
                if ($urandom_range(9) == 0) begin
                    n = $urandom_range(10, 1);
                    for (int k = 0; k < n; k++)
                        send_byte(t_byte'($urandom), k == n - 1);
                end else begin
                    if (count == MAX_COUNT || count == 32'd0)
                        target = $urandom_range(12, 1);
                    else
                        target = count;
                    send_image(target, $urandom_range(3) == 0, $urandom_range(4) == 0);
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("checked %0d runs from %0d decoded bytes: %0d images completed, %0d cut short",
                 sb.runs_checked, sb.live_bytes, sb.images_done, sb.truncations);
        $display("mismatches: %0d, runs still outstanding: %0d",
                 sb.errors, sb.pending_runs.size());
        if (sb.errors == 0 && sb.pending_runs.size() == 0)
            $display("tga_rle_pixel_decoder test passed");
        else
            $display("tga_rle_pixel_decoder test failed");
        $finish;
    end
endmodule
